// ===== hw/rtl/owdm_pkg.sv =====
// Shared types, constants and the sine table of the omni-wheel drive mixer.
// Used by owdm_front, owdm_queue, owdm_back and omni_wheel_drive_mixer_core.
package owdm_pkg;

  // Wheel count: default and the most the job record carries
  localparam int unsigned MotorCountDef = 4;
  localparam int unsigned MaxMotors     = 4;

  // Port field widths
  localparam int unsigned HeadW  = 9;
  localparam int unsigned SpeedW = 7;
  localparam int unsigned TurnW  = 8;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned ValueW = 13;
  localparam int unsigned ModeW  = 3;

  // Internal widths
  localparam int unsigned MagW   = 10;          // sine magnitude, 0..1000
  localparam int unsigned BaseW  = 11;          // translation scale magnitude
  localparam int unsigned SpinW  = 12;          // signed rotation term
  localparam int unsigned ProdW  = MagW + BaseW;
  localparam int unsigned QuoW   = 12;          // quotient bits, covers any base
  localparam int unsigned ScaleW = 18;          // operand of the /100 reciprocal

  localparam int unsigned QueueDepth = 2;

  // align_mode codes
  localparam logic [ModeW-1:0] ModeAroundBall = 3'd0;
  localparam logic [ModeW-1:0] ModeNoTurn     = 3'd3;
  localparam logic [ModeW-1:0] ModeReset      = 3'd2;

  // Angles in degrees
  localparam int unsigned QuarterDeg = 90;
  localparam int unsigned HalfDeg    = 180;
  localparam int unsigned ThreeQDeg  = 270;
  localparam int unsigned FullDeg    = 360;

  // Scaling
  localparam int unsigned Percent   = 100;
  localparam int unsigned FullScale = 923;
  localparam int          Deadband  = 1125;
  localparam int          DriveMax  = (1 <<< (ValueW - 1)) - 1;
  localparam int          DriveMin  = -(1 <<< (ValueW - 1));

  // Around-ball: wheels below this index are zeroed, this one is tripled
  localparam logic [IdxW-1:0] AroundBoostWheel = 2'd2;

  // ceil(2^24/100): exact truncating /100 for operands below 199728
  localparam logic [ScaleW-1:0] Recip100 = 18'd167773;
  localparam int unsigned       RecipShift = 24;

  // Quarter-wave sine, 0..90 degrees, scaled to 1000
  localparam logic [MagW-1:0] QuarterSine [QuarterDeg+1] = '{
    10'd0,   10'd17,  10'd34,  10'd52,  10'd69,  10'd87,  10'd104, 10'd121, 10'd139,
    10'd156, 10'd173, 10'd190, 10'd207, 10'd224, 10'd241, 10'd258, 10'd275, 10'd292,
    10'd309, 10'd325, 10'd342, 10'd358, 10'd374, 10'd390, 10'd406, 10'd422, 10'd438,
    10'd453, 10'd469, 10'd484, 10'd499, 10'd515, 10'd529, 10'd544, 10'd559, 10'd573,
    10'd587, 10'd601, 10'd615, 10'd629, 10'd642, 10'd656, 10'd669, 10'd681, 10'd694,
    10'd707, 10'd719, 10'd731, 10'd743, 10'd754, 10'd766, 10'd777, 10'd788, 10'd798,
    10'd809, 10'd819, 10'd829, 10'd838, 10'd848, 10'd857, 10'd866, 10'd874, 10'd882,
    10'd891, 10'd898, 10'd906, 10'd913, 10'd920, 10'd927, 10'd933, 10'd939, 10'd945,
    10'd951, 10'd956, 10'd961, 10'd965, 10'd970, 10'd974, 10'd978, 10'd981, 10'd984,
    10'd987, 10'd990, 10'd992, 10'd994, 10'd996, 10'd997, 10'd998, 10'd999, 10'd999,
    10'd1000
  };

  // One command, classified and scaled, waiting for the wheel loop
  typedef struct packed {
    logic [MaxMotors-1:0][MagW-1:0] sine_mag;
    logic [MaxMotors-1:0]           sine_neg;
    logic [MagW-1:0]                peak;
    logic [BaseW-1:0]               base_mag;
    logic                           base_neg;
    logic signed [SpinW-1:0]        spin;
    logic                           around;
  } job_t;

  // Truncating divide by 100 through a reciprocal multiply
  function automatic logic [QuoW-1:0] div100(input logic [ScaleW-1:0] m);
    logic [2*ScaleW-1:0] prod;
    prod = (2*ScaleW)'(m) * (2*ScaleW)'(Recip100);
    return prod[RecipShift +: QuoW];
  endfunction

endpackage

// ===== hw/rtl/owdm_front.sv =====
// Front end of the drive mixer: takes commands, looks up wheel sines, finds
// the peak and computes the translation and rotation scales. Uses owdm_pkg.
module owdm_front import owdm_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = MotorCountDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [ModeW-1:0]        mode_i,
  input  logic                    cmd_valid_i,
  output logic                    cmd_stall_o,
  input  logic [HeadW-1:0]        heading_i,
  input  logic [SpeedW-1:0]       drive_speed_i,
  input  logic signed [TurnW-1:0] turn_speed_i,
  output logic                    job_valid_o,
  input  logic                    job_full_i,
  output job_t                    job_o
);

  // Sine of an angle 0..359: sign and magnitude from the quarter table
  function automatic logic [MagW:0] sine_lookup(input logic [HeadW-1:0] d);
    logic [6:0] ix;
    logic       neg;
    if (d < HeadW'(QuarterDeg)) begin
      ix  = d[6:0];
      neg = 1'b0;
    end else if (d < HeadW'(HalfDeg)) begin
      ix  = 7'(HeadW'(HalfDeg) - d);
      neg = 1'b0;
    end else if (d < HeadW'(ThreeQDeg)) begin
      ix  = 7'(d - HeadW'(HalfDeg));
      neg = 1'b1;
    end else begin
      ix  = 7'(HeadW'(FullDeg) - d);
      neg = 1'b1;
    end
    return {neg, QuarterSine[ix]};
  endfunction

  logic en;
  logic vld1_q, vld2_q, vld3_q, vld4_q;

  // Pipe moves unless the last stage holds a job the queue cannot take
  assign en          = !(vld4_q && job_full_i);
  assign cmd_stall_o = !en;
  assign job_valid_o = vld4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else if (en) begin
      vld1_q <= cmd_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // Stage 1: capture and classify by mode
  logic [HeadW-1:0]        head1_q;
  logic [SpeedW-1:0]       speed1_q;
  logic signed [TurnW-1:0] turn1_q;
  logic                    around1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      head1_q   <= heading_i;
      speed1_q  <= drive_speed_i;
      turn1_q   <= (mode_i == ModeNoTurn) ? '0 : turn_speed_i;
      around1_q <= (mode_i == ModeAroundBall);
    end
  end

  // Stage 2: wheel sines and the two percent products
  logic [HeadW-1:0]               hd;
  logic [MaxMotors-1:0][MagW-1:0] smag;
  logic [MaxMotors-1:0]           sneg;
  logic [TurnW-1:0]               tmag;
  logic signed [TurnW:0]          t100;
  logic [SpeedW-1:0]              t100_mag;

  assign hd = (head1_q >= HeadW'(FullDeg)) ? HeadW'(head1_q - HeadW'(FullDeg)) : head1_q;

  for (genvar g = 0; g < MaxMotors; g++) begin : g_wheel
    if (g < MOTOR_COUNT) begin : g_used
      localparam int unsigned Offs = QuarterDeg * (MOTOR_COUNT - 2 + 4 * g) / MOTOR_COUNT;
      logic signed [HeadW:0] dd;
      logic [HeadW-1:0]      d;
      assign dd = $signed({1'b0, hd}) - $signed((HeadW+1)'(Offs));
      assign d  = (dd < 0) ? HeadW'(dd + $signed((HeadW+1)'(FullDeg))) : HeadW'(dd);
      assign {sneg[g], smag[g]} = sine_lookup(d);
    end else begin : g_unused
      assign sneg[g] = 1'b0;
      assign smag[g] = '0;
    end
  end

  assign tmag     = turn1_q[TurnW-1] ? TurnW'(-turn1_q) : TurnW'(turn1_q);
  assign t100     = $signed((TurnW+1)'(Percent)) - $signed({1'b0, tmag});
  assign t100_mag = t100[TurnW] ? SpeedW'(-t100) : SpeedW'(t100);

  logic [MaxMotors-1:0][MagW-1:0] smag2_q;
  logic [MaxMotors-1:0]           sneg2_q;
  logic [2*SpeedW-1:0]            pb2_q;
  logic                           pbneg2_q;
  logic [TurnW+SpeedW-1:0]        ps2_q;
  logic                           psneg2_q;
  logic                           around2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      smag2_q   <= smag;
      sneg2_q   <= sneg;
      pb2_q     <= (2*SpeedW)'(t100_mag) * (2*SpeedW)'(speed1_q);
      pbneg2_q  <= t100[TurnW];
      ps2_q     <= (TurnW+SpeedW)'(tmag) * (TurnW+SpeedW)'(speed1_q);
      psneg2_q  <= turn1_q[TurnW-1];
      around2_q <= around1_q;
    end
  end

  // Stage 3: peak magnitude, first /100
  logic [MagW-1:0] peak;
  logic [QuoW-1:0] qb, qs;

  always_comb begin
    peak = '0;
    for (int i = 0; i < MaxMotors; i++) begin
      if (smag2_q[i] > peak) peak = smag2_q[i];
    end
  end

  assign qb = div100(ScaleW'(pb2_q));
  assign qs = div100(ScaleW'(ps2_q));

  logic [MaxMotors-1:0][MagW-1:0] smag3_q;
  logic [MaxMotors-1:0]           sneg3_q;
  logic [MagW-1:0]                peak3_q;
  logic [TurnW-1:0]               qb3_q, qs3_q;
  logic                           pbneg3_q, psneg3_q, around3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      smag3_q   <= smag2_q;
      sneg3_q   <= sneg2_q;
      peak3_q   <= peak;
      qb3_q     <= qb[TurnW-1:0];
      qs3_q     <= qs[TurnW-1:0];
      pbneg3_q  <= pbneg2_q;
      psneg3_q  <= psneg2_q;
      around3_q <= around2_q;
    end
  end

  // Stage 4: scale to motor units
  logic [MaxMotors-1:0][MagW-1:0] smag4_q;
  logic [MaxMotors-1:0]           sneg4_q;
  logic [MagW-1:0]                peak4_q;
  logic [ScaleW-1:0]              mb4_q, ms4_q;
  logic                           pbneg4_q, psneg4_q, around4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      smag4_q   <= smag3_q;
      sneg4_q   <= sneg3_q;
      peak4_q   <= peak3_q;
      mb4_q     <= ScaleW'(qb3_q) * ScaleW'(FullScale);
      ms4_q     <= ScaleW'(qs3_q) * ScaleW'(FullScale);
      pbneg4_q  <= pbneg3_q;
      psneg4_q  <= psneg3_q;
      around4_q <= around3_q;
    end
  end

  // Second /100 feeds the queue write
  logic [QuoW-1:0] base_full, spin_full;

  assign base_full = div100(mb4_q);
  assign spin_full = div100(ms4_q);

  always_comb begin
    job_o.sine_mag = smag4_q;
    job_o.sine_neg = sneg4_q;
    job_o.peak     = peak4_q;
    job_o.base_mag = base_full[BaseW-1:0];
    job_o.base_neg = pbneg4_q;
    job_o.spin     = psneg4_q ? -$signed(SpinW'(spin_full[BaseW-1:0]))
                              : $signed(SpinW'(spin_full[BaseW-1:0]));
    job_o.around   = around4_q;
  end

endmodule

// ===== hw/rtl/owdm_queue.sv =====
// Two-entry job queue between the drive mixer front and back ends.
// Uses owdm_pkg for the job record.
module owdm_queue import owdm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output job_t rd_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/owdm_back.sv =====
// Drive mixer back end (uses owdm_pkg): walks one job's wheels, one per cycle
// unless stalled, through a multiplier, a pipelined divider and the output stage.
module owdm_back import owdm_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = MotorCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_empty_i,
  input  job_t                     job_i,
  output logic                     job_pop_o,
  output logic                     drive_valid_o,
  input  logic                     drive_stall_i,
  output logic [IdxW-1:0]          wheel_index_o,
  output logic signed [ValueW-1:0] drive_value_o,
  output logic                     last_o
);

  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned DivStages     = QuoW / StepsPerStage;
  localparam int unsigned WideW         = 16;

  // One wheel in flight through the divider
  typedef struct packed {
    logic [MagW-1:0]         rem;
    logic [QuoW-1:0]         num;
    logic [QuoW-1:0]         quo;
    logic [MagW-1:0]         peak;
    logic                    neg;
    logic signed [SpinW-1:0] spin;
    logic                    around;
    logic [IdxW-1:0]         idx;
    logic                    last;
  } dv_t;

  // Restoring division, a few quotient bits per stage
  function automatic dv_t div_steps(input dv_t s);
    dv_t           r;
    logic [MagW:0] trial;
    r = s;
    for (int j = 0; j < StepsPerStage; j++) begin
      trial = {r.rem, r.num[QuoW-1]};
      r.num = {r.num[QuoW-2:0], 1'b0};
      if (trial >= {1'b0, r.peak}) begin
        trial = trial - {1'b0, r.peak};
        r.quo = {r.quo[QuoW-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QuoW-2:0], 1'b0};
      end
      r.rem = trial[MagW-1:0];
    end
    return r;
  endfunction

  logic            en, issue, last_wheel;
  logic [IdxW-1:0] idx_q;
  logic            out_vld_q;

  assign en         = !out_vld_q || !drive_stall_i;
  assign issue      = en && !job_empty_i;
  assign last_wheel = (idx_q == IdxW'(MOTOR_COUNT - 1));
  assign job_pop_o  = issue && last_wheel;

  // Wheel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (issue) begin
      idx_q <= last_wheel ? '0 : IdxW'(idx_q + 1'b1);
    end
  end

  // Issue: sine times base scale
  logic [ProdW-1:0] prod;
  dv_t              dv_in;

  assign prod = ProdW'(job_i.sine_mag[idx_q]) * ProdW'(job_i.base_mag);

  always_comb begin
    dv_in.rem    = MagW'(prod[ProdW-1:QuoW]);
    dv_in.num    = prod[QuoW-1:0];
    dv_in.quo    = '0;
    dv_in.peak   = job_i.peak;
    dv_in.neg    = job_i.sine_neg[idx_q] ^ job_i.base_neg;
    dv_in.spin   = job_i.spin;
    dv_in.around = job_i.around;
    dv_in.idx    = idx_q;
    dv_in.last   = last_wheel;
  end

  dv_t                dv_q  [DivStages+1];
  logic [DivStages:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DivStages-1:0], issue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= dv_in;
    end
  end

  // Divider pipeline
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= div_steps(dv_q[k]);
      end
    end
  end

  // Sign, rotation term, around-ball rule, deadband and saturation
  dv_t                     fin;
  logic signed [QuoW+1:0]  qv, sum;
  logic signed [WideW-1:0] mixed, pushed;
  logic signed [ValueW-1:0] sat;

  assign fin = dv_q[DivStages];

  always_comb begin
    if (fin.peak == '0) begin
      qv = '0;
    end else if (fin.neg) begin
      qv = -$signed({2'b00, fin.quo});
    end else begin
      qv = $signed({2'b00, fin.quo});
    end
    sum = qv + (QuoW+2)'(fin.spin);
    if (fin.around && fin.idx < AroundBoostWheel) begin
      mixed = '0;
    end else if (fin.around && fin.idx == AroundBoostWheel) begin
      mixed = (WideW'(sum) <<< 1) + WideW'(sum);
    end else begin
      mixed = WideW'(sum);
    end
    if (mixed > 0) begin
      pushed = mixed + WideW'(Deadband);
    end else if (mixed < 0) begin
      pushed = mixed - WideW'(Deadband);
    end else begin
      pushed = '0;
    end
    if (pushed > WideW'(DriveMax)) begin
      sat = ValueW'(DriveMax);
    end else if (pushed < WideW'(DriveMin)) begin
      sat = ValueW'(DriveMin);
    end else begin
      sat = ValueW'(pushed);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wheel_index_o <= fin.idx;
      drive_value_o <= sat;
      last_o        <= fin.last;
    end
  end

  assign drive_valid_o = out_vld_q;

endmodule

// ===== hw/rtl/omni_wheel_drive_mixer_core.sv =====
// Omni-wheel drive mixer: one command (heading, speed, turn) in, one signed
// motor beat per wheel out, wheel 0 first, last set on the final wheel. The
// back end walks a command's wheels one a cycle unless the output stalls,
// through its single sine-by-scale multiplier and divider pipeline, and takes
// the next command only once the last wheel has issued. With the back end idle,
// a command passes four front stages (the first loaded at the edge that accepts
// it), the job queue, the multiply, three divider stages and the output register
// before its first beat is valid. The two-entry job queue lets the front take
// new commands while the back end is stalled. The user must write align_mode
// only while the block is idle; the block does not enforce it.
module omni_wheel_drive_mixer_core import owdm_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = MotorCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     align_mode_we_i,
  input  logic [ModeW-1:0]         align_mode_i,
  input  logic                     cmd_valid_i,
  output logic                     cmd_stall_o,
  input  logic [HeadW-1:0]         heading_i,
  input  logic [SpeedW-1:0]        drive_speed_i,
  input  logic signed [TurnW-1:0]  turn_speed_i,
  output logic                     drive_valid_o,
  input  logic                     drive_stall_i,
  output logic [IdxW-1:0]          wheel_index_o,
  output logic signed [ValueW-1:0] drive_value_o,
  output logic                     last_o
);

  // Mode register
  logic [ModeW-1:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (align_mode_we_i) begin
      mode_q <= align_mode_i;
    end
  end

  job_t front_job, back_job;
  logic job_valid, job_full, job_empty, job_pop;

  owdm_front #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .cmd_valid_i   (cmd_valid_i),
    .cmd_stall_o   (cmd_stall_o),
    .heading_i     (heading_i),
    .drive_speed_i (drive_speed_i),
    .turn_speed_i  (turn_speed_i),
    .job_valid_o   (job_valid),
    .job_full_i    (job_full),
    .job_o         (front_job)
  );

  owdm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_valid),
    .wr_data_i (front_job),
    .full_o    (job_full),
    .rd_i      (job_pop),
    .empty_o   (job_empty),
    .rd_data_o (back_job)
  );

  owdm_back #(
    .MOTOR_COUNT(MOTOR_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_empty_i   (job_empty),
    .job_i         (back_job),
    .job_pop_o     (job_pop),
    .drive_valid_o (drive_valid_o),
    .drive_stall_i (drive_stall_i),
    .wheel_index_o (wheel_index_o),
    .drive_value_o (drive_value_o),
    .last_o        (last_o)
  );

endmodule
